@@ hw/rtl/lrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types, register indexes, reset values and helpers of the link
// reconnect supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

    // Connection state of the supervisor.
    typedef enum logic [1:0] {
        LINK_IDLE       = 2'd0,
        LINK_CONNECTING = 2'd1,
        LINK_RETRY      = 2'd2,
        LINK_CONNECTED  = 2'd3
    } link_state_t;

    // Command codes of one pass; the unused code acts as a normal pass.
    localparam logic [1:0] CMD_PASS  = 2'd0;
    localparam logic [1:0] CMD_INIT  = 2'd1;
    localparam logic [1:0] CMD_FORCE = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONNECT_TIMEOUT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_MIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_MAX     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAILS_FALLBACK  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_LINGER = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY_LIMIT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CREDENTIALS     = 3'd6;
    localparam int unsigned CFG_DATA_W = 30;

    // Configuration reset values.
    localparam logic [15:0] CONNECT_TIMEOUT_RESET = 16'd15000;
    localparam logic [15:0] BACKOFF_MIN_RESET     = 16'd2000;
    localparam logic [15:0] BACKOFF_MAX_RESET     = 16'd60000;
    localparam logic [7:0]  FAILS_FALLBACK_RESET  = 8'd3;
    localparam logic [23:0] FALLBACK_LINGER_RESET = 24'd120000;
    localparam logic [29:0] RECOVERY_LIMIT_RESET  = 30'd1200000;

    // Saturation value of the failure counter.
    localparam logic [7:0] FAILS_MAX = 8'hFF;

    // Configuration registers.
    typedef struct packed {
        logic [15:0] attempt_limit_ms;
        logic [15:0] retry_floor_ms;
        logic [15:0] retry_ceiling_ms;
        logic [7:0]  fails_before_fallback;
        logic [23:0] fallback_linger_ms;
        logic [29:0] recovery_limit_ms;
        logic        credentials_present;
    } lrs_cfg_t;

    // Supervisor state carried from pass to pass.
    typedef struct packed {
        link_state_t mode;
        logic        fallback_open;
        logic        was_online;
        logic [31:0] time_now;
        logic [31:0] attempt_start;
        logic [31:0] retry_deadline;
        logic [15:0] backoff_now;
        logic [31:0] online_stamp;
        logic [31:0] linger_deadline;
        logic [7:0]  fails_now;
        logic [31:0] drop_counter;
        logic [7:0]  reason_store;
    } lrs_state_t;

    // One input transaction.
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] elapsed_ms;
        logic        got_address;
        logic        link_lost;
        logic        link_up;
        logic [7:0]  lost_reason;
    } lrs_item_t;

    // One result transaction.
    typedef struct packed {
        link_state_t link_state;
        logic        fallback_active;
        logic        begin_attempt;
        logic        open_fallback;
        logic        close_fallback;
        logic        restart_request;
        logic        resync_request;
        logic [7:0]  fail_count;
        logic [15:0] retry_delay_ms;
        logic [31:0] disconnect_total;
        logic        ever_online;
        logic [7:0]  last_reason;
    } lrs_result_t;

    // A deadline is reached when the wrapped difference is not negative.
    function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
        logic [31:0] diff;
        diff = now - deadline;
        return ~diff[31];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lrs_item_if.sv @@
// ----------------------------------------------------------------------------
// lrs_item_if
// Valid/ready channel carrying one supervisor pass request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] elapsed_ms;
    logic        got_address;
    logic        link_lost;
    logic        link_up;
    logic [7:0]  lost_reason;

    modport source (
        output valid, command, elapsed_ms, got_address, link_lost, link_up, lost_reason,
        input  ready
    );

    modport sink (
        input  valid, command, elapsed_ms, got_address, link_lost, link_up, lost_reason,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/lrs_result_if.sv @@
// ----------------------------------------------------------------------------
// lrs_result_if
// Valid/ready channel carrying one supervisor pass result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrs_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  link_state;
    logic        fallback_active;
    logic        begin_attempt;
    logic        open_fallback;
    logic        close_fallback;
    logic        restart_request;
    logic        resync_request;
    logic [7:0]  fail_count;
    logic [15:0] retry_delay_ms;
    logic [31:0] disconnect_total;
    logic        ever_online;
    logic [7:0]  last_reason;

    modport source (
        output valid, link_state, fallback_active, begin_attempt, open_fallback,
               close_fallback, restart_request, resync_request, fail_count,
               retry_delay_ms, disconnect_total, ever_online, last_reason,
        input  ready
    );

    modport sink (
        input  valid, link_state, fallback_active, begin_attempt, open_fallback,
               close_fallback, restart_request, resync_request, fail_count,
               retry_delay_ms, disconnect_total, ever_online, last_reason,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/link_reconnect_supervisor_core.sv @@
// ----------------------------------------------------------------------------
// link_reconnect_supervisor_core
// Reconnect supervisor with exponential backoff and a fallback access point.
//
// Each transaction on the item channel is one supervisor pass: elapsed time,
// the link events, the polled link status and a command. Each pass gives
// exactly one transaction on the result channel with the connection state,
// the event pulses and the counters after that pass.
// An accepted item is held in an input register; once the result register is
// free, the pass logic works it against the state registers and loads the
// result register. One item can be accepted every cycle while the receiver
// takes each result, limited by the single state update per cycle.
// When the receiver stalls, the waiting result holds, one further item may
// wait in the input register, and only then does ready fall.
// The configuration port writes one register per cycle by index; indexes
// beyond the list are ignored. The user must make writes only while no pass
// is pending; the block itself does not enforce it. Reset clears the state,
// reloads the configuration defaults and empties both registers; the block
// accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module link_reconnect_supervisor_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wen,
    input  wire [lrs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [lrs_pkg::CFG_DATA_W-1:0]       cfg_data,
    lrs_item_if.sink                            item,
    lrs_result_if.source                        result
);

    lrs_pkg::lrs_cfg_t    cfg_reg;
    lrs_pkg::lrs_state_t  state_reg;
    lrs_pkg::lrs_state_t  state_next;
    lrs_pkg::lrs_item_t   item_reg;
    lrs_pkg::lrs_result_t res_reg;
    lrs_pkg::lrs_result_t res_next;
    logic                 item_valid_reg;
    logic                 res_valid_reg;
    logic                 accept;
    logic                 fire;

    // Handshake control.
    assign fire       = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || fire;
    assign accept     = item.valid && item.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attempt_limit_ms      <= lrs_pkg::CONNECT_TIMEOUT_RESET;
            cfg_reg.retry_floor_ms        <= lrs_pkg::BACKOFF_MIN_RESET;
            cfg_reg.retry_ceiling_ms      <= lrs_pkg::BACKOFF_MAX_RESET;
            cfg_reg.fails_before_fallback <= lrs_pkg::FAILS_FALLBACK_RESET;
            cfg_reg.fallback_linger_ms    <= lrs_pkg::FALLBACK_LINGER_RESET;
            cfg_reg.recovery_limit_ms     <= lrs_pkg::RECOVERY_LIMIT_RESET;
            cfg_reg.credentials_present   <= 1'b0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                lrs_pkg::CFG_CONNECT_TIMEOUT: cfg_reg.attempt_limit_ms   <= cfg_data[15:0];
                lrs_pkg::CFG_BACKOFF_MIN:     cfg_reg.retry_floor_ms     <= cfg_data[15:0];
                lrs_pkg::CFG_BACKOFF_MAX:     cfg_reg.retry_ceiling_ms   <= cfg_data[15:0];
                lrs_pkg::CFG_FAILS_FALLBACK:  cfg_reg.fails_before_fallback <= cfg_data[7:0];
                lrs_pkg::CFG_FALLBACK_LINGER: cfg_reg.fallback_linger_ms <= cfg_data[23:0];
                lrs_pkg::CFG_RECOVERY_LIMIT:  cfg_reg.recovery_limit_ms  <= cfg_data[29:0];
                lrs_pkg::CFG_CREDENTIALS:     cfg_reg.credentials_present <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command     <= item.command;
            item_reg.elapsed_ms  <= item.elapsed_ms;
            item_reg.got_address <= item.got_address;
            item_reg.link_lost   <= item.link_lost;
            item_reg.link_up     <= item.link_up;
            item_reg.lost_reason <= item.lost_reason;
        end
    end

    // Pass logic.
    lrs_pass u_pass (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Supervisor state, updated once per pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode            <= lrs_pkg::LINK_IDLE;
            state_reg.fallback_open   <= 1'b0;
            state_reg.was_online      <= 1'b0;
            state_reg.time_now        <= '0;
            state_reg.attempt_start   <= '0;
            state_reg.retry_deadline  <= '0;
            state_reg.backoff_now     <= lrs_pkg::BACKOFF_MIN_RESET;
            state_reg.online_stamp    <= '0;
            state_reg.linger_deadline <= '0;
            state_reg.fails_now       <= '0;
            state_reg.drop_counter    <= '0;
            state_reg.reason_store    <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // Result channel.
    assign result.valid            = res_valid_reg;
    assign result.link_state       = res_reg.link_state;
    assign result.fallback_active  = res_reg.fallback_active;
    assign result.begin_attempt    = res_reg.begin_attempt;
    assign result.open_fallback    = res_reg.open_fallback;
    assign result.close_fallback   = res_reg.close_fallback;
    assign result.restart_request  = res_reg.restart_request;
    assign result.resync_request   = res_reg.resync_request;
    assign result.fail_count       = res_reg.fail_count;
    assign result.retry_delay_ms   = res_reg.retry_delay_ms;
    assign result.disconnect_total = res_reg.disconnect_total;
    assign result.ever_online      = res_reg.ever_online;
    assign result.last_reason      = res_reg.last_reason;

endmodule

`default_nettype wire

@@ hw/rtl/lrs_pass.sv @@
// ----------------------------------------------------------------------------
// lrs_pass
// Combinational next-state logic of one supervisor pass: time advance,
// command, events, state machine and offline recovery check.
// ----------------------------------------------------------------------------
`default_nettype none

module lrs_pass (
    input  var lrs_pkg::lrs_cfg_t    cfg,
    input  var lrs_pkg::lrs_state_t  cur,
    input  var lrs_pkg::lrs_item_t   item,
    output lrs_pkg::lrs_state_t      nxt,
    output lrs_pkg::lrs_result_t     res
);

    logic [31:0] time_adv;
    logic [16:0] backoff_dbl;
    logic [7:0]  fails_inc;
    logic        pulse_begin;
    logic        pulse_open;
    logic        pulse_close;
    logic        pulse_resync;
    logic        restart;

    always_comb
    begin
        nxt          = cur;
        pulse_begin  = 1'b0;
        pulse_open   = 1'b0;
        pulse_close  = 1'b0;
        pulse_resync = 1'b0;
        fails_inc    = cur.fails_now;
        backoff_dbl  = '0;

        // Advance the time counter.
        time_adv     = cur.time_now + {16'b0, item.elapsed_ms};
        nxt.time_now = time_adv;

        // Init and force reconnect restart the sequence.
        if (item.command == lrs_pkg::CMD_INIT || item.command == lrs_pkg::CMD_FORCE)
        begin
            nxt.backoff_now = cfg.retry_floor_ms;
            nxt.fails_now   = '0;
            if (cfg.credentials_present)
            begin
                nxt.attempt_start = time_adv;
                nxt.mode          = lrs_pkg::LINK_CONNECTING;
                pulse_begin       = 1'b1;
            end
            else
            begin
                nxt.mode = lrs_pkg::LINK_IDLE;
                if (!nxt.fallback_open)
                begin
                    nxt.fallback_open   = 1'b1;
                    nxt.linger_deadline = '0;
                    pulse_open          = 1'b1;
                end
            end
        end

        // Address obtained: the link is up.
        if (item.got_address)
        begin
            nxt.was_online   = 1'b1;
            nxt.mode         = lrs_pkg::LINK_CONNECTED;
            nxt.online_stamp = time_adv;
            nxt.fails_now    = '0;
            nxt.backoff_now  = cfg.retry_floor_ms;
            pulse_resync     = 1'b1;
            if (nxt.fallback_open && nxt.linger_deadline == 32'd0)
            begin
                nxt.linger_deadline = time_adv + {8'b0, cfg.fallback_linger_ms};
            end
        end

        // Disconnect event; only a connected link schedules an immediate retry.
        if (item.link_lost)
        begin
            nxt.reason_store = item.lost_reason;
            if (nxt.mode == lrs_pkg::LINK_CONNECTED)
            begin
                nxt.drop_counter   = nxt.drop_counter + 32'd1;
                nxt.backoff_now    = cfg.retry_floor_ms;
                nxt.fails_now      = '0;
                nxt.mode           = lrs_pkg::LINK_RETRY;
                nxt.retry_deadline = time_adv;
            end
        end

        // State machine step.
        unique case (nxt.mode)
            lrs_pkg::LINK_CONNECTING:
            begin
                if (lrs_pkg::reached(time_adv,
                        nxt.attempt_start + {16'b0, cfg.attempt_limit_ms}))
                begin
                    if (nxt.fails_now != lrs_pkg::FAILS_MAX)
                    begin
                        fails_inc = nxt.fails_now + 8'd1;
                    end
                    else
                    begin
                        fails_inc = nxt.fails_now;
                    end
                    nxt.fails_now = fails_inc;
                    if (fails_inc >= cfg.fails_before_fallback && !nxt.fallback_open)
                    begin
                        nxt.fallback_open   = 1'b1;
                        nxt.linger_deadline = '0;
                        pulse_open          = 1'b1;
                    end
                    // Schedule the retry and double the delay up to the limit.
                    backoff_dbl        = {nxt.backoff_now, 1'b0};
                    nxt.retry_deadline = time_adv + {16'b0, nxt.backoff_now};
                    nxt.mode           = lrs_pkg::LINK_RETRY;
                    if (backoff_dbl < {1'b0, cfg.retry_ceiling_ms})
                    begin
                        nxt.backoff_now = backoff_dbl[15:0];
                    end
                    else
                    begin
                        nxt.backoff_now = cfg.retry_ceiling_ms;
                    end
                end
            end
            lrs_pkg::LINK_RETRY:
            begin
                if (cfg.credentials_present && lrs_pkg::reached(time_adv, nxt.retry_deadline))
                begin
                    nxt.attempt_start = time_adv;
                    nxt.mode          = lrs_pkg::LINK_CONNECTING;
                    pulse_begin       = 1'b1;
                end
            end
            lrs_pkg::LINK_CONNECTED:
            begin
                nxt.online_stamp = time_adv;
                if (!item.link_up)
                begin
                    nxt.drop_counter   = nxt.drop_counter + 32'd1;
                    nxt.backoff_now    = cfg.retry_floor_ms;
                    nxt.mode           = lrs_pkg::LINK_RETRY;
                    nxt.retry_deadline = time_adv;
                end
                else if (nxt.fallback_open && nxt.linger_deadline != 32'd0
                         && lrs_pkg::reached(time_adv, nxt.linger_deadline))
                begin
                    nxt.fallback_open = 1'b0;
                    pulse_close       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Offline for too long after having been online.
        restart = nxt.was_online && nxt.mode != lrs_pkg::LINK_CONNECTED
                  && lrs_pkg::reached(time_adv,
                         nxt.online_stamp + {2'b0, cfg.recovery_limit_ms});

        // Result of the pass.
        res.link_state       = nxt.mode;
        res.fallback_active  = nxt.fallback_open;
        res.begin_attempt    = pulse_begin;
        res.open_fallback    = pulse_open;
        res.close_fallback   = pulse_close;
        res.restart_request  = restart;
        res.resync_request   = pulse_resync;
        res.fail_count       = nxt.fails_now;
        res.retry_delay_ms   = nxt.backoff_now;
        res.disconnect_total = nxt.drop_counter;
        res.ever_online      = nxt.was_online;
        res.last_reason      = nxt.reason_store;
    end

endmodule

`default_nettype wire

@@ tb/sv/link_reconnect_supervisor_core_tb.sv @@
// ----------------------------------------------------------------------------
// link_reconnect_supervisor_core_tb
// Self-checking testbench for the link reconnect supervisor. A queue of
// supervisor passes feeds a valid/ready driver. An in-bench model of the
// supervisor predicts one report per accepted pass. A monitor compares every
// report field by field, in order. Both channels stall in random bursts while
// jitter is on. The run covers directed corner cases, closing and re-arming
// the fallback linger, and random traffic under several register settings.
// ----------------------------------------------------------------------------

module link_reconnect_supervisor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrs_pkg::*;

    // Unused command code and unused register index, both treated as no-ops.
    localparam logic [1:0]             CMD_SPARE  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    // Linger time used while closing and re-arming the fallback.
    localparam logic [23:0] LINGER_SHORT = 24'd200000;
    localparam int          STUCK_LIMIT  = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lrs_item_if   item_ch ();
    lrs_result_if result_ch ();

    link_reconnect_supervisor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model state and register copy of the supervisor.
    lrs_state_t  sup;
    lrs_cfg_t    sup_cfg;

    lrs_item_t   pass_backlog[$];
    lrs_result_t expected_reports[$];
    lrs_item_t   cur_pass;
    logic [31:0] gen_clock;
    logic        jitter_on;
    int          gap_left;
    int          stall_left;
    int          stuck_cycles;
    int          fault_count;
    int          reports_seen;

    // ------------------------------------------------------------------------
    // Supervisor model
    // ------------------------------------------------------------------------

    // A deadline counts as reached once the wrapped distance to it is not negative.
    function automatic logic deadline_met(input logic [31:0] now, input logic [31:0] mark);
        return $signed(now - mark) >= 0;
    endfunction

    // Opens the fallback access point; returns 1 only if it was closed before.
    function automatic logic raise_fallback();
        if (sup.fallback_open)
            return 1'b0;
        sup.fallback_open   = 1'b1;
        sup.linger_deadline = '0;
        return 1'b1;
    endfunction

    task automatic reset_model();
        sup_cfg.attempt_limit_ms      = CONNECT_TIMEOUT_RESET;
        sup_cfg.retry_floor_ms        = BACKOFF_MIN_RESET;
        sup_cfg.retry_ceiling_ms      = BACKOFF_MAX_RESET;
        sup_cfg.fails_before_fallback = FAILS_FALLBACK_RESET;
        sup_cfg.fallback_linger_ms    = FALLBACK_LINGER_RESET;
        sup_cfg.recovery_limit_ms     = RECOVERY_LIMIT_RESET;
        sup_cfg.credentials_present   = 1'b0;
        sup             = '0;
        sup.mode        = LINK_IDLE;
        sup.backoff_now = BACKOFF_MIN_RESET;
    endtask

    // Runs one supervisor pass on the model and returns the report it gives.
    function automatic lrs_result_t predict_pass(input lrs_item_t it);
        lrs_result_t rep;
        logic        fire_begin;
        logic        fire_open;
        logic        fire_close;
        logic        fire_resync;
        logic        want_restart;
        logic [16:0] doubled;

        fire_begin  = 1'b0;
        fire_open   = 1'b0;
        fire_close  = 1'b0;
        fire_resync = 1'b0;
        sup.time_now = sup.time_now + 32'(it.elapsed_ms);

        // Commands restart the sequence before the events are looked at.
        if (it.command == CMD_INIT || it.command == CMD_FORCE)
        begin
            sup.backoff_now = sup_cfg.retry_floor_ms;
            sup.fails_now   = '0;
            if (sup_cfg.credentials_present)
            begin
                sup.attempt_start = sup.time_now;
                sup.mode          = LINK_CONNECTING;
                fire_begin        = 1'b1;
            end
            else
            begin
                sup.mode = LINK_IDLE;
                if (raise_fallback())
                    fire_open = 1'b1;
            end
        end

        if (it.got_address)
        begin
            sup.was_online   = 1'b1;
            sup.mode         = LINK_CONNECTED;
            sup.online_stamp = sup.time_now;
            sup.fails_now    = '0;
            sup.backoff_now  = sup_cfg.retry_floor_ms;
            fire_resync      = 1'b1;
            if (sup.fallback_open && sup.linger_deadline == '0)
                sup.linger_deadline = sup.time_now + 32'(sup_cfg.fallback_linger_ms);
        end

        // A loss event only counts while connected; the reason is always kept.
        if (it.link_lost)
        begin
            sup.reason_store = it.lost_reason;
            if (sup.mode == LINK_CONNECTED)
            begin
                sup.drop_counter   = sup.drop_counter + 32'd1;
                sup.backoff_now    = sup_cfg.retry_floor_ms;
                sup.fails_now      = '0;
                sup.mode           = LINK_RETRY;
                sup.retry_deadline = sup.time_now;
            end
        end

        case (sup.mode)
            LINK_CONNECTING:
            begin
                if (deadline_met(sup.time_now,
                                 sup.attempt_start + 32'(sup_cfg.attempt_limit_ms)))
                begin
                    if (sup.fails_now != FAILS_MAX)
                        sup.fails_now = sup.fails_now + 8'd1;
                    if (sup.fails_now >= sup_cfg.fails_before_fallback && raise_fallback())
                        fire_open = 1'b1;
                    sup.retry_deadline = sup.time_now + 32'(sup.backoff_now);
                    sup.mode           = LINK_RETRY;
                    doubled            = {sup.backoff_now, 1'b0};
                    sup.backoff_now    = (doubled < {1'b0, sup_cfg.retry_ceiling_ms})
                                         ? doubled[15:0] : sup_cfg.retry_ceiling_ms;
                end
            end
            LINK_RETRY:
            begin
                if (sup_cfg.credentials_present && deadline_met(sup.time_now, sup.retry_deadline))
                begin
                    sup.attempt_start = sup.time_now;
                    sup.mode          = LINK_CONNECTING;
                    fire_begin        = 1'b1;
                end
            end
            LINK_CONNECTED:
            begin
                sup.online_stamp = sup.time_now;
                if (!it.link_up)
                begin
                    sup.drop_counter   = sup.drop_counter + 32'd1;
                    sup.backoff_now    = sup_cfg.retry_floor_ms;
                    sup.mode           = LINK_RETRY;
                    sup.retry_deadline = sup.time_now;
                end
                else if (sup.fallback_open && sup.linger_deadline != '0 &&
                         deadline_met(sup.time_now, sup.linger_deadline))
                begin
                    sup.fallback_open = 1'b0;
                    fire_close        = 1'b1;
                end
            end
            default: ;
        endcase

        want_restart = sup.was_online && sup.mode != LINK_CONNECTED &&
                       deadline_met(sup.time_now,
                                    sup.online_stamp + 32'(sup_cfg.recovery_limit_ms));

        rep.link_state       = sup.mode;
        rep.fallback_active  = sup.fallback_open;
        rep.begin_attempt    = fire_begin;
        rep.open_fallback    = fire_open;
        rep.close_fallback   = fire_close;
        rep.restart_request  = want_restart;
        rep.resync_request   = fire_resync;
        rep.fail_count       = sup.fails_now;
        rep.retry_delay_ms   = sup.backoff_now;
        rep.disconnect_total = sup.drop_counter;
        rep.ever_online      = sup.was_online;
        rep.last_reason      = sup.reason_store;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic lrs_item_t make_pass(input logic [1:0] cmd, input logic [15:0] elapsed,
                                            input logic got, input logic lost, input logic up,
                                            input logic [7:0] reason);
        lrs_item_t it;
        it.command     = cmd;
        it.elapsed_ms  = elapsed;
        it.got_address = got;
        it.link_lost   = lost;
        it.link_up     = up;
        it.lost_reason = reason;
        return it;
    endfunction

    // Mostly plain passes with a live link; events and commands are occasional.
    function automatic lrs_item_t random_pass(input int unsigned lo, input int unsigned hi,
                                              input int unsigned got_pct,
                                              input int unsigned cmd_pct);
        lrs_item_t   it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < cmd_pct / 3)
            it.command = CMD_INIT;
        else if (pick < (2 * cmd_pct) / 3)
            it.command = CMD_FORCE;
        else if (pick < cmd_pct)
            it.command = CMD_SPARE;
        else
            it.command = CMD_PASS;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.elapsed_ms = 16'(lo);
        else if (pick == 1)
            it.elapsed_ms = 16'(hi);
        else
            it.elapsed_ms = 16'($urandom_range(lo, hi));
        it.got_address = ($urandom_range(0, 99) < got_pct);
        it.link_lost   = ($urandom_range(0, 99) < 8);
        it.link_up     = ($urandom_range(0, 9) != 0);
        it.lost_reason = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic queue_pass(input lrs_item_t it);
        gen_clock = gen_clock + 32'(it.elapsed_ms);
        pass_backlog.push_back(it);
    endtask

    // Waits until every queued pass has been reported, then a few quiet cycles.
    task automatic wait_drained();
        while (pass_backlog.size() != 0 || expected_reports.size() != 0 || item_ch.valid)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        case (idx)
            CFG_CONNECT_TIMEOUT: sup_cfg.attempt_limit_ms      = value[15:0];
            CFG_BACKOFF_MIN:     sup_cfg.retry_floor_ms        = value[15:0];
            CFG_BACKOFF_MAX:     sup_cfg.retry_ceiling_ms      = value[15:0];
            CFG_FAILS_FALLBACK:  sup_cfg.fails_before_fallback = value[7:0];
            CFG_FALLBACK_LINGER: sup_cfg.fallback_linger_ms    = value[23:0];
            CFG_RECOVERY_LIMIT:  sup_cfg.recovery_limit_ms     = value[29:0];
            CFG_CREDENTIALS:     sup_cfg.credentials_present   = value[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] timeout, input logic [15:0] bmin,
                                 input logic [15:0] bmax, input logic [7:0] fails,
                                 input logic [23:0] linger, input logic [29:0] recovery,
                                 input logic cred);
        write_reg(CFG_CONNECT_TIMEOUT, CFG_DATA_W'(timeout));
        write_reg(CFG_BACKOFF_MIN, CFG_DATA_W'(bmin));
        write_reg(CFG_BACKOFF_MAX, CFG_DATA_W'(bmax));
        write_reg(CFG_FAILS_FALLBACK, CFG_DATA_W'(fails));
        write_reg(CFG_FALLBACK_LINGER, CFG_DATA_W'(linger));
        write_reg(CFG_RECOVERY_LIMIT, CFG_DATA_W'(recovery));
        write_reg(CFG_CREDENTIALS, CFG_DATA_W'(cred));
    endtask

    // ------------------------------------------------------------------------
    // Report checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string label, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("report %0d: %s is %0h, expected %0h", reports_seen, label, got, want);
        end
    endtask

    task automatic check_report();
        lrs_result_t want;
        reports_seen++;
        if (expected_reports.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("report %0d arrived with no pass outstanding", reports_seen);
            return;
        end
        want = expected_reports.pop_front();
        check_field("link_state", 32'(result_ch.link_state), 32'(want.link_state));
        check_field("fallback_active", 32'(result_ch.fallback_active),
                    32'(want.fallback_active));
        check_field("begin_attempt", 32'(result_ch.begin_attempt), 32'(want.begin_attempt));
        check_field("open_fallback", 32'(result_ch.open_fallback), 32'(want.open_fallback));
        check_field("close_fallback", 32'(result_ch.close_fallback),
                    32'(want.close_fallback));
        check_field("restart_request", 32'(result_ch.restart_request),
                    32'(want.restart_request));
        check_field("resync_request", 32'(result_ch.resync_request),
                    32'(want.resync_request));
        check_field("fail_count", 32'(result_ch.fail_count), 32'(want.fail_count));
        check_field("retry_delay_ms", 32'(result_ch.retry_delay_ms),
                    32'(want.retry_delay_ms));
        check_field("disconnect_total", result_ch.disconnect_total, want.disconnect_total);
        check_field("ever_online", 32'(result_ch.ever_online), 32'(want.ever_online));
        check_field("last_reason", 32'(result_ch.last_reason), 32'(want.last_reason));
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued passes, predicts each accepted transaction and
    // leaves random gaps between transactions while jitter is on.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                expected_reports.push_back(predict_pass(cur_pass));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pass_backlog.size() != 0)
                begin
                    cur_pass = pass_backlog.pop_front();
                    item_ch.valid       <= 1'b1;
                    item_ch.command     <= cur_pass.command;
                    item_ch.elapsed_ms  <= cur_pass.elapsed_ms;
                    item_ch.got_address <= cur_pass.got_address;
                    item_ch.link_lost   <= cur_pass.link_lost;
                    item_ch.link_up     <= cur_pass.link_up;
                    item_ch.lost_reason <= cur_pass.lost_reason;
                    if (jitter_on && $urandom_range(0, 4) == 0)
                        gap_left <= $urandom_range(1, 8);
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted report and stalls the result channel in
    // random bursts while jitter is on.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                check_report();
            if (stall_left != 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= stall_left - 1;
            end
            else if (jitter_on && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= $urandom_range(0, 7);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Counts cycles in which work is outstanding but no transaction moves.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (pass_backlog.size() == 0 && expected_reports.size() == 0 && !item_ch.valid))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_wen             = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_PASS;
        item_ch.elapsed_ms  = '0;
        item_ch.got_address = 1'b0;
        item_ch.link_lost   = 1'b0;
        item_ch.link_up     = 1'b0;
        item_ch.lost_reason = '0;
        result_ch.ready     = 1'b0;
        jitter_on           = 1'b1;
        gen_clock           = '0;
        stuck_cycles        = 0;
        fault_count         = 0;
        reports_seen        = 0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, no credentials: unknown command, a loss outside the
        // connected state, commands without credentials, both events at once.
        queue_pass(make_pass(CMD_PASS, 16'd0, 1'b0, 1'b0, 1'b0, 8'h00));
        queue_pass(make_pass(CMD_SPARE, 16'hFFFF, 1'b0, 1'b1, 1'b0, 8'hFF));
        queue_pass(make_pass(CMD_INIT, 16'd1, 1'b0, 1'b0, 1'b0, 8'h00));
        queue_pass(make_pass(CMD_FORCE, 16'd1, 1'b0, 1'b0, 1'b0, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd1, 1'b1, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'hFFFF, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd7, 1'b0, 1'b0, 1'b0, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd3, 1'b1, 1'b1, 1'b1, 8'h5A));
        wait_drained();

        // Zero timeout ends a fresh attempt in the same pass; zero failure
        // threshold is met on the first failure, with the fallback already open.
        load_settings(16'd0, 16'd1, 16'hFFFF, 8'd0, 24'hFFFFFF, 30'd1, 1'b1);
        queue_pass(make_pass(CMD_INIT, 16'd0, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd0, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd1, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd0, 1'b0, 1'b0, 1'b1, 8'h00));
        wait_drained();

        // Largest timeout and delay with the smallest maximum: backoff clamps.
        load_settings(16'hFFFF, 16'hFFFF, 16'd1, 8'hFF, 24'd1, 30'h3FFFFFFF, 1'b1);
        queue_pass(make_pass(CMD_FORCE, 16'd0, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'hFFFF, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'hFFFF, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd5, 1'b1, 1'b0, 1'b1, 8'h00));
        wait_drained();

        // Close the fallback, reopen it with the linger unset, then connect
        // again so that the linger is armed afresh.
        load_settings(16'd15000, 16'd2000, 16'd60000, 8'd3, LINGER_SHORT, 30'd600000, 1'b0);
        for (int n = 0; n < 400 && sup.fallback_open; n++)
        begin
            queue_pass(make_pass(CMD_PASS, 16'hFFFF, 1'b1, 1'b0, 1'b1, 8'h00));
            wait_drained();
        end
        queue_pass(make_pass(CMD_INIT, 16'd1, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd100, 1'b1, 1'b0, 1'b1, 8'h00));
        repeat (3)
            queue_pass(make_pass(CMD_PASS, 16'hFFFF, 1'b0, 1'b0, 1'b1, 8'h00));
        queue_pass(make_pass(CMD_PASS, 16'd10, 1'b0, 1'b1, 1'b1, 8'h33));
        queue_pass(make_pass(CMD_PASS, 16'd10, 1'b1, 1'b0, 1'b1, 8'h00));
        repeat (20)
            queue_pass(make_pass(CMD_PASS, 16'hFFFF, 1'b0, 1'b0, 1'b1, 8'h00));
        wait_drained();

        // Failure storm: every attempt times out, driving the failure count up
        // towards saturation under the highest fallback threshold.
        load_settings(16'd0, 16'd1, 16'd2, 8'hFF, 24'd1, 30'h3FFFFFFF, 1'b1);
        queue_pass(make_pass(CMD_FORCE, 16'd2, 1'b0, 1'b0, 1'b1, 8'h00));
        repeat (500)
            queue_pass(random_pass(2, 40, 0, 0));
        wait_drained();

        // Reset-like settings; the timeout write carries junk above its width.
        load_settings(16'd15000, 16'd2000, 16'd60000, 8'd3, 24'd120000, 30'd1200000, 1'b1);
        write_reg(CFG_CONNECT_TIMEOUT, 30'h2AAA_3A98);
        repeat (160)
            queue_pass(random_pass(0, 65535, 12, 6));
        wait_drained();

        // Smallest settings: attempts fail at once and recovery trips quickly.
        load_settings(16'd1, 16'd1, 16'd1, 8'd1, 24'd1, 30'd1, 1'b1);
        repeat (120)
            queue_pass(random_pass(0, 4, 15, 6));
        wait_drained();

        // Largest settings without credentials.
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 24'hFFFFFF, 30'h3FFFFFFF, 1'b0);
        repeat (80)
            queue_pass(random_pass(0, 65535, 10, 10));
        wait_drained();

        // Mid-range settings at full rate; a write to an unused index is ignored.
        load_settings(16'd5000, 16'd500, 16'd8000, 8'd4, 24'd30000, 30'd90000, 1'b1);
        write_reg(CFG_UNUSED, 30'h3FFFFFFF);
        jitter_on = 1'b0;
        repeat (150)
            queue_pass(random_pass(0, 3000, 10, 4));
        wait_drained();

        repeat (8) @(posedge clk);
        if (fault_count == 0 && expected_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_item_if.sv
hw/rtl/lrs_result_if.sv
hw/rtl/lrs_pass.sv
hw/rtl/link_reconnect_supervisor_core.sv
tb/sv/link_reconnect_supervisor_core_tb.sv
